// ===== hw/rtl/sle_pkg.sv =====
// Shared types and constants for the supply loss event detector.
// No dependencies; imported by sle_log and supply_loss_event_detector.
`default_nettype none

package sle_pkg;

  // ring log
  localparam int LOG_DEPTH = 10;
  localparam int SLOT_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  // measurement window on the free-running read timer
  localparam int READ_INTERVAL = 600;

  // qualification constants
  localparam logic [7:0] LOSS_RUN_PROBE  = 8'd29;
  localparam logic [7:0] CURRENT_TIMEOUT = 8'd25;
  localparam logic [7:0] RUN_SAT         = 8'hFF;
  localparam logic [7:0] EVENTS_SAT      = 8'hFF;

  localparam logic [47:0] OPEN_END_MARK = 48'hFFFF_FFFF_FFFF;

  // loss seconds are kept as minutes plus seconds-within-minute
  localparam int          SECONDS_PER_MIN = 60;
  localparam logic [31:0] LOSS_SEC_MAX    = 32'hFFFF_FFFF;
  localparam int          MIN_W           = 27;
  localparam int          SEC_W           = 6;
  localparam logic [MIN_W-1:0] LOSS_MIN_SAT = MIN_W'(LOSS_SEC_MAX / SECONDS_PER_MIN);
  localparam logic [SEC_W-1:0] LOSS_REM_SAT = SEC_W'(LOSS_SEC_MAX % SECONDS_PER_MIN);
  localparam logic [SEC_W-1:0] SEC_LAST     = SEC_W'(SECONDS_PER_MIN - 1);

  // config register reset values
  localparam logic       RST_RECORD_EN  = 1'b0;
  localparam logic [9:0] RST_MIN_PULSES = 10'd35;
  localparam logic [9:0] RST_MAX_PULSES = 10'd252;
  localparam logic [7:0] RST_START_SEC  = 8'd30;
  localparam logic [7:0] RST_END_SEC    = 8'd30;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECORD_EN  = 3'd0,
    CFG_MIN_PULSES = 3'd1,
    CFG_MAX_PULSES = 3'd2,
    CFG_START_SEC  = 3'd3,
    CFG_END_SEC    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SUMMARY = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // lowest set bit of a positive constant
  function automatic int low_zero_bits(input int v);
    int n;
    n = 0;
    for (int i = 30; i >= 0; i--) begin
      if (((v >> i) & 1) == 1) n = i;
    end
    return n;
  endfunction

  // inverse of an odd constant mod 2**32 (Newton steps, 3 -> 96 good bits)
  function automatic logic [31:0] odd_inverse(input logic [31:0] d);
    logic [31:0] inv;
    inv = d;
    for (int i = 0; i < 5; i++) begin
      inv = inv * (32'd2 - d * inv);
    end
    return inv;
  endfunction

  // t % READ_INTERVAL == 0: low zero bits plus an odd-divisor test by one multiply
  localparam int          RI_TZ       = low_zero_bits(READ_INTERVAL);
  localparam logic [31:0] RI_ODD      = 32'(READ_INTERVAL >> RI_TZ);
  localparam logic [31:0] RI_INV      = odd_inverse(RI_ODD);
  localparam logic [31:0] RI_LIMIT    = 32'hFFFF_FFFF / RI_ODD;
  localparam logic [31:0] RI_LOW_MASK = (32'd1 << RI_TZ) - 32'd1;

  typedef struct packed {
    op_t          op;
    logic [9:0]   pulse_count;
    logic         sense_pin_low;
    logic         current_valid_set;
    logic         measure_closed;
    logic         meter_power_on;
    logic [31:0]  read_timer;
    logic [31:0]  peak_current;
    logic [47:0]  clock_time;
    logic [3:0]   record_index;
  } item_t;

  typedef struct packed {
    logic              event_started;
    logic              event_ended;
    logic              open_power_request;
    logic              clear_current;
    logic [MIN_W-1:0]  loss_minutes;
    logic [7:0]        event_count;
    logic              data_valid;
    logic [47:0]       record_start_time;
    logic [47:0]       record_end_time;
    logic [31:0]       record_current;
  } result_t;

  // log write controls from the event logic
  typedef struct packed {
    logic              open_we;
    logic              close_we;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       stamp;
    logic [31:0]       current;
  } log_wr_t;

  typedef struct packed {
    logic [47:0] start_time;
    logic [47:0] end_time;
    logic [31:0] current;
  } log_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/supply_loss_event_detector.sv =====
// Supply loss event detector: per-second loss qualification, event start/end,
// ring log of events and power-on summary. Depends on sle_pkg and sle_log.
//
//   channel   dir  handshake                 payload
//   item      in   item_valid / item_stall   item (sle_pkg::item_t)
//   result    out  result_valid / result_stall  result (sle_pkg::result_t)
//   cfg       in   cfg_we                    cfg_index, cfg_data
//
// One item per clock while item_stall is low. The result is registered and shows in the
// cycle after the item is taken; all state updates in that same edge.
// item_stall follows result_stall only while the result register is full.
// Reset is synchronous; the log reads as zeros through its per-slot valid bits.
`default_nettype none

module supply_loss_event_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire sle_pkg::item_t                    item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output sle_pkg::result_t                       result,
  input  wire logic                              cfg_we,
  input  wire logic [sle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sle_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sle_pkg::*;

  // configuration
  logic       record_current_enable;
  logic [9:0] min_pulses;
  logic [9:0] max_pulses;
  logic [7:0] start_seconds;
  logic [7:0] end_seconds;

  // event state
  logic              event_open,   event_open_next;
  logic [7:0]        loss_run,     loss_run_next;
  logic [7:0]        clean_run,    clean_run_next;
  logic [MIN_W-1:0]  loss_minutes, loss_minutes_next;
  logic [SEC_W-1:0]  loss_sec_mod, loss_sec_mod_next;
  logic [7:0]        events_seen,  events_seen_next;
  logic [SLOT_W-1:0] write_slot,   write_slot_next;
  logic              valid_mark,   valid_mark_next;
  logic              current_ok,   current_ok_next;
  logic              measuring,    measuring_next;

  result_t  result_next;
  result_t  result_core;
  log_wr_t  log_wr;
  log_rec_t log_rec;

  logic              accept;
  logic              cur_ok_in;
  logic              meas_in;
  logic              loss_second;
  logic              timer_slot;
  logic [31:0]       timer_prod;
  logic [7:0]        loss_run_inc;
  logic [7:0]        clean_run_inc;
  logic              loss_sat;
  logic              loss_add;
  logic              close_now;
  logic [SLOT_W-1:0] slot_after;

  assign accept     = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_current_enable <= RST_RECORD_EN;
      min_pulses            <= RST_MIN_PULSES;
      max_pulses            <= RST_MAX_PULSES;
      start_seconds         <= RST_START_SEC;
      end_seconds           <= RST_END_SEC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECORD_EN:  record_current_enable <= cfg_data[0];
        CFG_MIN_PULSES: min_pulses            <= cfg_data[9:0];
        CFG_MAX_PULSES: max_pulses            <= cfg_data[9:0];
        CFG_START_SEC:  start_seconds         <= cfg_data[7:0];
        CFG_END_SEC:    end_seconds           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // outside flags act before anything else on every item
  assign cur_ok_in = current_ok || item.current_valid_set;
  assign meas_in   = measuring && !item.measure_closed;

  assign loss_second = ((item.pulse_count >= min_pulses) &&
                        (item.pulse_count <= max_pulses)) || meas_in;

  assign timer_prod = (item.read_timer >> RI_TZ) * RI_INV;
  assign timer_slot = ((item.read_timer & RI_LOW_MASK) == 32'd0) &&
                      (timer_prod <= RI_LIMIT);

  assign loss_run_inc  = (loss_run  == RUN_SAT) ? loss_run  : loss_run  + 8'd1;
  assign clean_run_inc = (clean_run == RUN_SAT) ? clean_run : clean_run + 8'd1;
  assign loss_sat      = (loss_minutes == LOSS_MIN_SAT) && (loss_sec_mod == LOSS_REM_SAT);
  assign slot_after    = (write_slot == SLOT_W'(LOG_DEPTH - 1)) ? '0 : write_slot + 1'b1;

  always_comb begin
    event_open_next = event_open;
    loss_run_next   = loss_run;
    clean_run_next  = clean_run;
    events_seen_next = events_seen;
    write_slot_next = write_slot;
    valid_mark_next = valid_mark;
    current_ok_next = cur_ok_in;
    measuring_next  = meas_in;
    loss_add        = 1'b0;
    close_now       = 1'b0;
    result_next     = '0;
    log_wr          = '0;
    log_wr.slot     = write_slot;
    log_wr.stamp    = item.clock_time;
    log_wr.current  = item.peak_current;

    case (item.op)
      OP_TICK: begin
        if (item.sense_pin_low) begin
          if (loss_second) begin
            if (record_current_enable && !item.meter_power_on &&
                ((loss_run >= LOSS_RUN_PROBE && !cur_ok_in && timer_slot) || meas_in)) begin
              result_next.open_power_request = 1'b1;
              measuring_next = 1'b1;
            end
            clean_run_next = '0;
            if (event_open) begin
              loss_add = 1'b1;
            end else if (loss_run_inc >= start_seconds &&
                         (!record_current_enable || cur_ok_in)) begin
              loss_run_next   = '0;
              log_wr.open_we  = 1'b1;
              event_open_next = 1'b1;
              events_seen_next = (events_seen == EVENTS_SAT) ? events_seen
                                                             : events_seen + 8'd1;
              valid_mark_next = 1'b1;
              result_next.event_started = 1'b1;
            end else begin
              loss_run_next = loss_run_inc;
            end
          end else begin
            loss_add = event_open;
            if (!cur_ok_in) loss_run_next = '0;
            clean_run_next = clean_run_inc;
            if (clean_run_inc > CURRENT_TIMEOUT) current_ok_next = 1'b0;
            if (clean_run_inc >= end_seconds && event_open) begin
              close_now = 1'b1;
              result_next.event_ended   = 1'b1;
              result_next.clear_current = 1'b1;
            end
          end
        end
      end
      OP_SUMMARY: begin
        if (valid_mark) begin
          if (event_open) begin
            close_now = 1'b1;
            result_next.event_ended = 1'b1;
          end
          result_next.loss_minutes = loss_minutes;
          result_next.event_count  = events_seen;
        end
      end
      // record fields come from the log's read word
      OP_READ: ;
      default: ;
    endcase

    if (close_now) begin
      log_wr.close_we = 1'b1;
      write_slot_next = slot_after;
      event_open_next = 1'b0;
    end

    loss_minutes_next = loss_minutes;
    loss_sec_mod_next = loss_sec_mod;
    if (loss_add && !loss_sat) begin
      if (loss_sec_mod == SEC_LAST) begin
        loss_sec_mod_next = '0;
        loss_minutes_next = loss_minutes + 1'b1;
      end else begin
        loss_sec_mod_next = loss_sec_mod + 1'b1;
      end
    end

    result_next.data_valid = valid_mark_next;

    if (!accept) begin
      log_wr.open_we  = 1'b0;
      log_wr.close_we = 1'b0;
    end
  end

  sle_log u_log (
    .clk      (clk),
    .rst      (rst),
    .wr       (log_wr),
    .rd_en    (accept),
    .rd_sel   (item.op == OP_READ),
    .rd_index (item.record_index),
    .rd_rec   (log_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_open   <= 1'b0;
      loss_run     <= '0;
      clean_run    <= '0;
      loss_minutes <= '0;
      loss_sec_mod <= '0;
      events_seen  <= '0;
      write_slot   <= '0;
      valid_mark   <= 1'b0;
      current_ok   <= 1'b0;
      measuring    <= 1'b0;
    end else if (accept) begin
      event_open   <= event_open_next;
      loss_run     <= loss_run_next;
      clean_run    <= clean_run_next;
      loss_minutes <= loss_minutes_next;
      loss_sec_mod <= loss_sec_mod_next;
      events_seen  <= events_seen_next;
      write_slot   <= write_slot_next;
      valid_mark   <= valid_mark_next;
      current_ok   <= current_ok_next;
      measuring    <= measuring_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_core <= result_next;
    end
  end

  always_comb begin
    result                   = result_core;
    result.record_start_time = log_rec.start_time;
    result.record_end_time   = log_rec.end_time;
    result.record_current    = log_rec.current;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sle_log.sv =====
// Ring log of event records: start time, end time, peak current per slot.
// Depends on sle_pkg. Per-slot valid bits give the all-zero reset image.
`default_nettype none

module sle_log (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sle_pkg::log_wr_t wr,
  input  wire logic             rd_en,
  input  wire logic             rd_sel,
  input  wire logic [3:0]       rd_index,
  output sle_pkg::log_rec_t     rd_rec
);
  import sle_pkg::*;

  logic [47:0]          start_mem   [LOG_DEPTH];
  logic [47:0]          end_mem     [LOG_DEPTH];
  logic [31:0]          current_mem [LOG_DEPTH];
  logic [LOG_DEPTH-1:0] slot_valid;
  logic [SLOT_W-1:0]    rd_slot;
  logic                 rd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.open_we) begin
      slot_valid[wr.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.open_we) begin
      start_mem[wr.slot]   <= wr.stamp;
      current_mem[wr.slot] <= wr.current;
      end_mem[wr.slot]     <= OPEN_END_MARK;
    end else if (wr.close_we) begin
      end_mem[wr.slot] <= wr.stamp;
    end
  end

  assign rd_slot = SLOT_W'(rd_index);
  assign rd_hit  = (32'(rd_index) < LOG_DEPTH);

  // read word loads with every accepted item; zeros unless a written slot is read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_rec <= '0;
    end else if (rd_en) begin
      if (rd_sel && rd_hit && slot_valid[rd_slot]) begin
        rd_rec.start_time <= start_mem[rd_slot];
        rd_rec.end_time   <= end_mem[rd_slot];
        rd_rec.current    <= current_mem[rd_slot];
      end else begin
        rd_rec <= '0;
      end
    end
  end

endmodule

`default_nettype wire
